// ===== hdl/rmg_pkg.sv =====
package rmg_pkg;

	// input transaction fields
	typedef struct packed {
		logic [1:0]         action;
		logic [9:0]         visible_index;
		logic [4:0]         hidden_index;
		logic signed [15:0] weight_value;
		logic [7:0]         pixel_value;
		logic               last_pixel;
	} in_item_t;

	// result transaction fields
	typedef struct packed {
		logic        kind;
		logic [9:0]  unit_index;
		logic [15:0] activation;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		ACT_WEIGHT = 2'd0,
		ACT_PIXEL  = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_PIXEL  = 2'd1,
		CMD_READ   = 2'd2
	} cmd_op_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_op_t     op;
		logic        store;
		logic        start;
		logic [9:0]  vidx;
		logic [15:0] waddr;
		logic [15:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_HMAC,
		ST_HACT,
		ST_VMAC,
		ST_VACT,
		ST_EMIT
	} st_t;

	// register indexes (paddr[2])
	localparam logic REG_INV_TEMP = 1'b0;
	localparam logic REG_FREE_RUN = 1'b1;

	localparam logic [15:0] INV_TEMP_RESET = 16'd2560;
	localparam logic [3:0]  FREE_RUN_RESET = 4'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = 2;

	// ceil(2^31 / 255): exact floor division by 255 for 23-bit dividends
	localparam logic [23:0] PIX_RECIP = 24'd8421505;

endpackage

// ===== hdl/rmg_ram.sv =====
module rmg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/rmg_front.sv =====
module rmg_front #(
	parameter int VISIBLE_UNITS = 784,
	parameter int HIDDEN_UNITS  = 20
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  rmg_pkg::in_item_t in_data,
	input  logic              q_full,
	input  logic              cleared,
	output logic              q_push,
	output rmg_pkg::cmd_t     q_cmd
);

	import rmg_pkg::*;

	logic        accept;
	logic        vi_ok;
	logic        hi_ok;
	logic        keep;
	logic [22:0] pix_x;
	logic [46:0] pix_prod;

	assign in_ready = !q_full && cleared;
	assign accept   = in_valid && in_ready;
	assign vi_ok    = int'(in_data.visible_index) < VISIBLE_UNITS;
	assign hi_ok    = int'(in_data.hidden_index) < HIDDEN_UNITS;

	// pixel * 32768 / 255, rounded, via reciprocal multiply
	assign pix_x    = {in_data.pixel_value, 15'd0} + 23'd127;
	assign pix_prod = 47'(pix_x) * 47'(PIX_RECIP);

	// classify the transaction into a command, or drop it
	always_comb begin
		keep        = 1'b0;
		q_cmd.op    = CMD_WEIGHT;
		q_cmd.store = 1'b0;
		q_cmd.start = 1'b0;
		q_cmd.vidx  = in_data.visible_index;
		q_cmd.waddr = 16'(int'(in_data.visible_index) * HIDDEN_UNITS
			+ int'(in_data.hidden_index));
		q_cmd.data  = in_data.weight_value;
		unique case (action_t'(in_data.action))
			ACT_WEIGHT: begin
				keep        = vi_ok && hi_ok;
				q_cmd.store = 1'b1;
			end
			ACT_PIXEL: begin
				keep        = vi_ok || in_data.last_pixel;
				q_cmd.op    = CMD_PIXEL;
				q_cmd.store = vi_ok;
				q_cmd.start = in_data.last_pixel;
				q_cmd.data  = pix_prod[46:31];
			end
			ACT_READ: begin
				keep     = vi_ok;
				q_cmd.op = CMD_READ;
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = accept && keep;

endmodule

// ===== hdl/rmg_fifo.sv =====
module rmg_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rmg_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output rmg_pkg::cmd_t pop_data,
	output logic          empty
);

	import rmg_pkg::*;

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QPW:0]   cnt_q;

	assign full     = cnt_q == (QPW+1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/rmg_back.sv =====
module rmg_back #(
	parameter int VISIBLE_UNITS   = 784,
	parameter int HIDDEN_UNITS    = 20,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  rmg_pkg::cmd_t      q_cmd,
	output logic               q_pop,
	output logic               cleared,
	input  logic [15:0]        inv_temp,
	input  logic [3:0]         free_run,
	output logic               out_valid,
	input  logic               out_ready,
	output rmg_pkg::out_item_t out_data
);

	import rmg_pkg::*;

	localparam int VW  = $clog2(VISIBLE_UNITS);
	localparam int HW  = HIDDEN_UNITS > 1 ? $clog2(HIDDEN_UNITS) : 1;
	localparam int UW  = VW > HW ? VW : HW;
	localparam int WD  = VISIBLE_UNITS * HIDDEN_UNITS;
	localparam int WAW = $clog2(WD);
	localparam int IW  = $clog2(SIGMOID_ENTRIES);
	localparam int SW  = 42 + IW;

	localparam logic [63:0] ONE_Q32  = 64'd4294967296;
	localparam logic [63:0] EXP_M1   = 64'd1580030169;
	localparam logic [63:0] HALF_POS = 64'd34359738368;

	localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
	localparam logic signed [33:0] SAT_LO = -34'sd2147483648;
	localparam logic signed [49:0] Z_OFF  = 50'sd1099511627776;

	typedef logic [15:0] sig_rom_t [SIGMOID_ENTRIES];

	// restoring division, used only while building the table
	function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid at bin centres over [-8, 8), Q1.15
	function automatic sig_rom_t build_sig();
		sig_rom_t    r;
		logic [63:0] pos;
		logic [63:0] a;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		longint      sum;
		logic        neg;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			pos  = div_u64(64'(2 * i + 1) << 35, 64'(SIGMOID_ENTRIES));
			neg  = pos < HALF_POS;
			a    = neg ? HALF_POS - pos : pos - HALF_POS;
			n    = a >> 32;
			f    = a & 64'hFFFF_FFFF;
			term = ONE_Q32;
			sum  = longint'(ONE_Q32);
			for (int k = 1; k <= 20; k++) begin
				term = div_u64((term * f) >> 32, 64'(k));
				if ((k & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			e = sum < 0 ? 64'd0 : 64'(sum);
			for (int j = 0; j < 8; j++) begin
				if (64'(j) < n) begin
					e = (e * EXP_M1) >> 32;
				end
			end
			d    = ONE_Q32 + e;
			num  = neg ? (e << 15) : (64'd1 << 47);
			r[i] = 16'(div_u64(num + (d >> 1), d));
		end
		return r;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig();

	st_t             state_q, state_d;
	logic [UW-1:0]   unit_q, unit_d;
	logic [UW-1:0]   elem_q, elem_d;
	logic [WAW-1:0]  waddr_q, waddr_d;
	logic [3:0]      pass_q, pass_d;

	logic            vram_we, vram_re;
	logic [VW-1:0]   vram_wa, vram_ra;
	logic [15:0]     vram_wd, vram_rd;
	logic            wram_we, wram_re;
	logic [WAW-1:0]  wram_wa, wram_ra;
	logic [15:0]     wram_wd, wram_rd;

	logic [15:0]     hid_q [HIDDEN_UNITS];
	logic [HW-1:0]   hid_ra;
	logic [15:0]     hid_rv;
	logic            hid_we;

	logic            issue, issue_last, issue_hsrc;
	logic            v_s1, last_s1, hsrc_s1;
	logic [15:0]     hid_s1;
	logic            v_s2, last_s2;
	logic signed [32:0] prod_s2;
	logic signed [31:0] acc_q;
	logic signed [33:0] acc_sum;
	logic signed [31:0] acc_sat;
	logic            f_s3, f_s4, f_s5, f_s6;
	logic signed [31:0] fin_s3;
	logic signed [48:0] z_s4;
	logic signed [49:0] z_t;
	logic [SW-1:0]   z_scl;
	logic [IW-1:0]   idx_d, idx_s5;
	logic [15:0]     act_s6;
	logic [15:0]     a_s1;

	logic            out_free, out_load;
	out_item_t       out_new;
	logic            out_valid_q;
	out_item_t       out_q;

	rmg_ram #(.WIDTH(16), .DEPTH(VISIBLE_UNITS)) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_wa),
		.wdata (vram_wd),
		.re    (vram_re),
		.raddr (vram_ra),
		.rdata (vram_rd)
	);

	rmg_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (wram_wa),
		.wdata (wram_wd),
		.re    (wram_re),
		.raddr (wram_ra),
		.rdata (wram_rd)
	);

	assign cleared   = state_q != ST_CLEAR;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign hid_ra    = (state_q == ST_EMIT) ? unit_q[HW-1:0] : elem_q[HW-1:0];
	assign hid_rv    = hid_q[hid_ra];

	// sequencer: commands, passes, emission
	always_comb begin
		state_d    = state_q;
		unit_d     = unit_q;
		elem_d     = elem_q;
		waddr_d    = waddr_q;
		pass_d     = pass_q;
		q_pop      = 1'b0;
		vram_we    = 1'b0;
		vram_wa    = elem_q[VW-1:0];
		vram_wd    = act_s6;
		vram_re    = 1'b0;
		vram_ra    = elem_q[VW-1:0];
		wram_we    = 1'b0;
		wram_wa    = q_cmd.waddr[WAW-1:0];
		wram_wd    = q_cmd.data;
		wram_re    = 1'b0;
		wram_ra    = waddr_q;
		hid_we     = 1'b0;
		issue      = 1'b0;
		issue_last = 1'b0;
		issue_hsrc = 1'b0;
		out_load   = 1'b0;
		out_new    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				vram_we = 1'b1;
				vram_wd = '0;
				if (elem_q == UW'(VISIBLE_UNITS - 1)) begin
					elem_d  = '0;
					state_d = ST_IDLE;
				end else begin
					elem_d = elem_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						CMD_WEIGHT: wram_we = 1'b1;
						CMD_PIXEL: begin
							vram_we = q_cmd.store;
							vram_wa = q_cmd.vidx[VW-1:0];
							vram_wd = q_cmd.data;
							if (q_cmd.start) begin
								unit_d  = '0;
								elem_d  = '0;
								waddr_d = '0;
								pass_d  = '0;
								state_d = ST_HMAC;
							end
						end
						CMD_READ: begin
							vram_re = 1'b1;
							vram_ra = q_cmd.vidx[VW-1:0];
							unit_d  = UW'(q_cmd.vidx);
							state_d = ST_READ;
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_new.kind       = 1'b1;
					out_new.unit_index = 10'(unit_q);
					out_new.activation = vram_rd;
					out_new.last       = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			ST_HMAC: begin
				wram_re    = 1'b1;
				vram_re    = 1'b1;
				issue      = 1'b1;
				issue_hsrc = 1'b1;
				issue_last = elem_q == UW'(VISIBLE_UNITS - 1);
				waddr_d    = waddr_q + WAW'(HIDDEN_UNITS);
				elem_d     = elem_q + 1'b1;
				if (issue_last) begin
					state_d = ST_HACT;
				end
			end
			ST_HACT: begin
				if (f_s6) begin
					hid_we = 1'b1;
					elem_d = '0;
					if (unit_q == UW'(HIDDEN_UNITS - 1)) begin
						unit_d  = '0;
						waddr_d = '0;
						state_d = ST_VMAC;
					end else begin
						unit_d  = unit_q + 1'b1;
						waddr_d = WAW'(unit_q) + WAW'(1);
						state_d = ST_HMAC;
					end
				end
			end
			ST_VMAC: begin
				wram_re    = 1'b1;
				issue      = 1'b1;
				issue_last = elem_q == UW'(HIDDEN_UNITS - 1);
				waddr_d    = waddr_q + 1'b1;
				elem_d     = elem_q + 1'b1;
				if (issue_last) begin
					state_d = ST_VACT;
				end
			end
			ST_VACT: begin
				if (f_s6) begin
					vram_we = 1'b1;
					vram_wa = unit_q[VW-1:0];
					elem_d  = '0;
					if (unit_q == UW'(VISIBLE_UNITS - 1)) begin
						unit_d = '0;
						if (pass_q == free_run) begin
							state_d = ST_EMIT;
						end else begin
							pass_d  = pass_q + 1'b1;
							waddr_d = '0;
							state_d = ST_HMAC;
						end
					end else begin
						unit_d  = unit_q + 1'b1;
						state_d = ST_VMAC;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_new.kind       = 1'b0;
					out_new.unit_index = 10'(unit_q);
					out_new.activation = hid_rv;
					out_new.last       = unit_q == UW'(HIDDEN_UNITS - 1);
					if (out_new.last) begin
						unit_d  = '0;
						state_d = ST_IDLE;
					end else begin
						unit_d = unit_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			unit_q  <= '0;
			elem_q  <= '0;
			waddr_q <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			unit_q  <= unit_d;
			elem_q  <= elem_d;
			waddr_q <= waddr_d;
			pass_q  <= pass_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hid_we) begin
			hid_q[unit_q[HW-1:0]] <= act_s6;
		end
	end

	// saturating accumulate of the registered product
	assign acc_sum = 34'(acc_q) + 34'(prod_s2);
	always_comb begin
		if (acc_sum > SAT_HI) begin
			acc_sat = 32'sh7FFF_FFFF;
		end else if (acc_sum < SAT_LO) begin
			acc_sat = -32'sh8000_0000;
		end else begin
			acc_sat = acc_sum[31:0];
		end
	end

	// table index from z = acc * inv_temp, clamped to the table
	assign z_t   = 50'(z_s4) + Z_OFF;
	assign z_scl = SW'(z_t[40:0]) * SW'(SIGMOID_ENTRIES);
	always_comb begin
		if (z_t < 0) begin
			idx_d = '0;
		end else if (|z_t[49:41]) begin
			idx_d = IW'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_d = z_scl[41+IW-1:41];
		end
	end

	assign a_s1 = hsrc_s1 ? vram_rd : hid_s1;

	// MAC and activation pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			f_s3        <= 1'b0;
			f_s4        <= 1'b0;
			f_s5        <= 1'b0;
			f_s6        <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			f_s3 <= v_s2 && last_s2;
			f_s4 <= f_s3;
			f_s5 <= f_s4;
			f_s6 <= f_s5;
			if (v_s2) begin
				acc_q <= last_s2 ? '0 : acc_sat;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// MAC and activation pipeline data
	always_ff @(posedge clk) begin
		last_s1 <= issue_last;
		hsrc_s1 <= issue_hsrc;
		hid_s1  <= hid_rv;
		last_s2 <= last_s1;
		prod_s2 <= $signed({1'b0, a_s1}) * $signed(wram_rd);
		fin_s3  <= acc_sat;
		z_s4    <= 49'(fin_s3) * 49'($signed({1'b0, inv_temp}));
		idx_s5  <= idx_d;
		act_s6  <= SIG_ROM[idx_s5];
		if (out_load) begin
			out_q <= out_new;
		end
	end

endmodule

// ===== hdl/rbm_mean_field_gibbs.sv =====
// Weight, pixel and read transactions are taken one per cycle into a 4-entry queue,
// while it is not full. Read result: the visible RAM is read when the command leaves
// the queue head, and the result is registered once the output is free. A run (last
// pixel) makes 1 + free_run passes on the single shared multiply-accumulate unit; the
// HIDDEN_UNITS hidden results then follow, one a cycle while out_ready holds. Reset is
// asynchronous; a clearing pass then zeroes the visible units and no transaction is taken.
module rbm_mean_field_gibbs #(
	parameter int VISIBLE_UNITS   = 784,
	parameter int HIDDEN_UNITS    = 20,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rmg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rmg_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	import rmg_pkg::*;

	logic        q_push, q_full, q_pop, q_empty, cleared;
	cmd_t        q_in, q_out;
	logic [15:0] inv_temp_q;
	logic [3:0]  free_run_q;
	logic        cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_temp_q <= INV_TEMP_RESET;
			free_run_q <= FREE_RUN_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INV_TEMP) begin
				inv_temp_q <= pwdata[15:0];
			end else begin
				free_run_q <= pwdata[3:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_FREE_RUN) ? {28'd0, free_run_q} : {16'd0, inv_temp_q};

	rmg_front #(
		.VISIBLE_UNITS (VISIBLE_UNITS),
		.HIDDEN_UNITS  (HIDDEN_UNITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.cleared  (cleared),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	rmg_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	rmg_back #(
		.VISIBLE_UNITS   (VISIBLE_UNITS),
		.HIDDEN_UNITS    (HIDDEN_UNITS),
		.SIGMOID_ENTRIES (SIGMOID_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_out),
		.q_pop     (q_pop),
		.cleared   (cleared),
		.inv_temp  (inv_temp_q),
		.free_run  (free_run_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/rmg_checker.sv =====
module rmg_checker #(
	parameter int HIDDEN_UNITS = 20
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input rmg_pkg::out_item_t out_data,
	input logic               pready
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// activations never exceed 1.0
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.activation <= 16'd32768)
		else $error("activation above 1.0");

	// a visible read result is always a single, last transaction
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> out_data.last)
		else $error("read result without last");

	// the run ends on the top hidden unit
	a_hid_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.kind && out_data.last
			|-> out_data.unit_index == 10'(HIDDEN_UNITS - 1))
		else $error("last marked on wrong hidden unit");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind rbm_mean_field_gibbs rmg_checker #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);
